FILE: rtl/mbgwa_pkg.sv
// Shared constants, codes and types for the median-baseline waveform averager.
package mbgwa_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_DETECTORS_DEF = 4;
  localparam int MAX_SAMPLES_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF   = 14;

  // Fixed field widths
  localparam int DET_W    = 2;
  localparam int BIN_W    = 10;
  localparam int MEAN_W   = 20;
  localparam int THR_W    = 20;
  localparam int LEN_W    = 11;
  localparam int MASK_W   = 4;
  localparam int SUM_W    = 40;
  localparam int SQ_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam int MEAN_LIM = 262144;

  // Reset values of the configuration registers
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);

  // Saturation limits of the accumulators
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SQ_W-1:0]         SQ_MAX  = {SQ_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEGATE = 2'd0,
    CFG_LENGTH = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic {
    KIND_SUMMARY = 1'b0,
    KIND_READOUT = 1'b1
  } kind_t;

endpackage

FILE: rtl/median_baseline_gated_wave_averager.sv
// Top level: waveform buffer, median select, gated mean and per-bin accumulation.
//
// Usage
//   Command channel: an item transfers on a rising edge with start high and busy
//   low. operation = push stores one sample of the current waveform; operation =
//   read returns the two accumulators of one (detector, bin).
//   Result channel: done is high for exactly one cycle with kind, source_detector,
//   event_mean, accepted, bin_sum and bin_sum_squares; the receiver cannot stall,
//   so each result is taken in that cycle.
//   Configuration: cfg_valid/cfg_ready write channel (cfg_ready is always high),
//   cfg_index selects negate_mask, wave_length or accept_threshold.
// Timing
//   A push that does not end a waveform gives no result.
//   A read registers its result and done in the S_RDBIN state.
//   The push that ends an n-sample waveform starts the end pass: SAMPLE_BITS
//   radix passes over the buffer memory (one buffer read per cycle), the setup
//   states S_MUL, S_NUM and S_CMP, a bit-serial divide, then the summary. If
//   accepted, a read-modify-write pass over the accumulator memories follows,
//   through S_ARD, S_ACALC and S_AWR for each sample. busy is high throughout.
// Reset
//   After rst the accumulator memories are cleared one entry per cycle, all
//   NUM_DETECTORS*MAX_SAMPLES entries (4096 by default), with busy high;
//   configuration writes are still taken.
module median_baseline_gated_wave_averager
  import mbgwa_pkg::*;
#(
  parameter int NUM_DETECTORS = NUM_DETECTORS_DEF,
  parameter int MAX_SAMPLES   = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic [DET_W-1:0]             detector,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic [BIN_W-1:0]             bin_index,
  output logic                         done,
  output logic                         kind,
  output logic [DET_W-1:0]             source_detector,
  output logic signed [MEAN_W-1:0]     event_mean,
  output logic                         accepted,
  output logic signed [SUM_W-1:0]      bin_sum,
  output logic [SQ_W-1:0]              bin_sum_squares,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int SB     = SAMPLE_BITS;
  localparam int AW     = $clog2(MAX_SAMPLES);
  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int ACC_D  = NUM_DETECTORS * MAX_SAMPLES;
  localparam int ACC_AW = $clog2(ACC_D);
  localparam int BW     = $clog2(SB);
  localparam int RAW_W  = SB + CW;          // sum of raw samples
  localparam int SQW    = SB + CW + 1;      // signed corrected sum
  localparam int NW     = SQW + 4;          // sum in 1/16 LSB
  localparam int TW     = THR_W + CW + 1;   // threshold times n
  localparam int EW     = (NW > TW) ? NW : TW;
  localparam int QW     = SB + 1;           // corrected sample
  localparam int PW     = 2 * QW;           // squared sample
  localparam int DCW    = $clog2(NW + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDBIN, S_SEL, S_MUL, S_NUM, S_CMP, S_DIV, S_FIN,
    S_ARD, S_ACALC, S_AWR
  } state_t;

  state_t state;

  // Configuration registers
  logic [MASK_W-1:0]       negate_mask;
  logic [LEN_W-1:0]        wave_length;
  logic signed [THR_W-1:0] accept_threshold;

  // Waveform collection
  logic [CW-1:0]    sample_count;
  logic [DET_W-1:0] wave_det;
  logic [CW-1:0]    n_r;

  // Median select
  logic [CW-1:0]    issue;
  logic             rd_v;
  logic [BW-1:0]    bpos;
  logic [SB-1:0]    prefix;
  logic [CW-1:0]    k_r;
  logic [CW-1:0]    cnt0;
  logic [RAW_W-1:0] sum_raw;

  // Mean and gate
  logic [RAW_W-1:0]        nb_r;
  logic signed [TW-1:0]    thrn_r;
  logic signed [NW-1:0]    num_r;
  logic                    acc_r;
  logic                    neg_num;
  logic [NW-1:0]           dvd;
  logic [CW:0]             rem;
  logic [DCW-1:0]          div_cnt;

  // Accumulation pass
  logic [CW-1:0]            ai;
  logic [ACC_AW-1:0]        acc_addr;
  logic signed [QW-1:0]     q_r;
  logic [PW-1:0]            sq_r;
  logic signed [SUM_W-1:0]  cur_sum;
  logic [SQ_W-1:0]          cur_sq;

  logic [ACC_AW-1:0] clr_addr;

  // Memory ports
  logic              buf_we, buf_re;
  logic [AW-1:0]     buf_waddr, buf_raddr;
  logic [SB-1:0]     buf_rdata;
  logic              acc_we, acc_re;
  logic [ACC_AW-1:0] acc_raddr, acc_waddr;
  logic signed [SUM_W-1:0] sum_wdata, sum_rdata;
  logic [SQ_W-1:0]   sq_wdata, sq_rdata;

  logic accept;
  logic neg;
  logic [CW-1:0] count_next;
  int   eff_len;
  logic [ACC_AW-1:0] wave_base_addr;
  logic [ACC_AW-1:0] read_addr;
  logic read_ok;
  logic sel_match;
  logic [SB-1:0] hi_diff;
  logic signed [QW-1:0] q_now;
  logic signed [SUM_W:0] sum_add;
  logic [SQ_W:0] sq_add;
  logic [CW:0] rem_sh;
  logic [NW:0] mean_mag;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign neg       = negate_mask[wave_det];

  // Effective length and next fill
  always_comb begin
    if (wave_length == '0) begin
      eff_len = 1;
    end else if (int'(wave_length) > MAX_SAMPLES) begin
      eff_len = MAX_SAMPLES;
    end else begin
      eff_len = int'(wave_length);
    end
    count_next = (int'(sample_count) < MAX_SAMPLES) ? sample_count + 1'b1 : sample_count;
  end

  // Addressing into the accumulators
  assign wave_base_addr = ACC_AW'(int'(wave_det) * MAX_SAMPLES);
  assign read_addr      = ACC_AW'(int'(detector) * MAX_SAMPLES + int'(bin_index));
  assign read_ok        = (int'(detector) < NUM_DETECTORS) && (int'(bin_index) < MAX_SAMPLES);

  // Radix select compare: upper bits match prefix and current bit is zero
  assign hi_diff   = (buf_rdata ^ prefix) >> ({1'b0, bpos} + 1'b1);
  assign sel_match = (hi_diff == '0) && !buf_rdata[bpos];

  // Corrected sample during accumulation
  always_comb begin
    q_now = $signed({1'b0, buf_rdata}) - $signed({1'b0, prefix});
    if (neg) begin
      q_now = -q_now;
    end
  end

  // Saturating adds for the write-back; zero data during the clear pass
  always_comb begin
    sum_add = (SUM_W+1)'(cur_sum) + (SUM_W+1)'(q_r);
    if (sum_add > (SUM_W+1)'(SUM_MAX)) begin
      sum_wdata = SUM_MAX;
    end else if (sum_add < (SUM_W+1)'(SUM_MIN)) begin
      sum_wdata = SUM_MIN;
    end else begin
      sum_wdata = sum_add[SUM_W-1:0];
    end
    sq_add = {1'b0, cur_sq} + (SQ_W+1)'(sq_r);
    sq_wdata = sq_add[SQ_W] ? SQ_MAX : sq_add[SQ_W-1:0];
    if (state == S_CLEAR) begin
      sum_wdata = '0;
      sq_wdata  = '0;
    end
  end

  assign rem_sh   = {rem[CW-1:0], dvd[NW-1]};
  assign mean_mag = {1'b0, dvd} + ((neg_num && rem != '0) ? 1'b1 : 1'b0);

  // Memory control
  always_comb begin
    buf_we    = (state == S_IDLE) && accept && (operation == OP_PUSH) &&
                (int'(sample_count) < MAX_SAMPLES);
    buf_waddr = sample_count[AW-1:0];
    buf_re    = ((state == S_SEL) && (issue < n_r)) || (state == S_ARD);
    buf_raddr = (state == S_ARD) ? ai[AW-1:0] : issue[AW-1:0];
    acc_re    = ((state == S_IDLE) && accept) || (state == S_ARD);
    acc_raddr = (state == S_ARD) ? wave_base_addr + ACC_AW'(ai) : read_addr;
    acc_we    = (state == S_CLEAR) || (state == S_AWR);
    acc_waddr = (state == S_CLEAR) ? clr_addr : acc_addr;
  end

  mbgwa_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_wave_buf (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(sample),
    .re(buf_re), .raddr(buf_raddr), .rdata(buf_rdata)
  );

  mbgwa_ram #(.WIDTH(SUM_W), .DEPTH(ACC_D)) u_sum_mem (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(sum_wdata),
    .re(acc_re), .raddr(acc_raddr), .rdata(sum_rdata)
  );

  mbgwa_ram #(.WIDTH(SQ_W), .DEPTH(ACC_D)) u_sq_mem (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(sq_wdata),
    .re(acc_re), .raddr(acc_raddr), .rdata(sq_rdata)
  );

  // Sequencer, datapath registers and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_addr         <= '0;
      sample_count     <= '0;
      wave_det         <= '0;
      negate_mask      <= '0;
      wave_length      <= LEN_RESET;
      accept_threshold <= THR_RESET;
      done             <= 1'b0;
      rd_v             <= 1'b0;
    end else begin
      // Result strobe follows the readout and summary states
      done <= (state == S_RDBIN) || (state == S_FIN);

      // Configuration transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NEGATE: negate_mask      <= cfg_data[MASK_W-1:0];
          CFG_LENGTH: wave_length      <= cfg_data[LEN_W-1:0];
          CFG_THRESH: accept_threshold <= cfg_data[THR_W-1:0];
          default:    ;
        endcase
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (int'(clr_addr) == ACC_D - 1) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            source_detector <= detector;
            if (operation == OP_READ) begin
              acc_r <= read_ok;
              state <= S_RDBIN;
            end else begin
              if (sample_count == '0) begin
                wave_det <= detector;
              end
              if (int'(count_next) >= eff_len) begin
                n_r          <= count_next;
                k_r          <= count_next >> 1;
                sample_count <= '0;
                issue        <= '0;
                rd_v         <= 1'b0;
                cnt0         <= '0;
                bpos         <= BW'(SB - 1);
                prefix       <= '0;
                sum_raw      <= '0;
                state        <= S_SEL;
              end else begin
                sample_count <= count_next;
              end
            end
          end
        end

        S_RDBIN: begin
          kind            <= KIND_READOUT;
          event_mean      <= '0;
          accepted        <= 1'b0;
          bin_sum         <= acc_r ? sum_rdata : '0;
          bin_sum_squares <= acc_r ? sq_rdata : '0;
          state           <= S_IDLE;
        end

        // One radix pass per bit, streaming the buffer
        S_SEL: begin
          rd_v <= (issue < n_r);
          if (issue < n_r) begin
            issue <= issue + 1'b1;
          end
          if (rd_v) begin
            if (int'(bpos) == SB - 1) begin
              sum_raw <= sum_raw + RAW_W'(buf_rdata);
            end
            if (sel_match) begin
              cnt0 <= cnt0 + 1'b1;
            end
          end
          if ((issue == n_r) && !rd_v) begin
            if (k_r >= cnt0) begin
              k_r          <= k_r - cnt0;
              prefix[bpos] <= 1'b1;
            end
            if (bpos == '0) begin
              state <= S_MUL;
            end else begin
              bpos  <= bpos - 1'b1;
              issue <= '0;
              cnt0  <= '0;
            end
          end
        end

        S_MUL: begin
          nb_r   <= RAW_W'(n_r) * RAW_W'(prefix);
          thrn_r <= TW'(accept_threshold) * TW'($signed({1'b0, n_r}));
          source_detector <= wave_det;
          state  <= S_NUM;
        end

        S_NUM: begin
          if (neg) begin
            num_r <= NW'($signed(SQW'(nb_r)) - $signed(SQW'(sum_raw))) <<< 4;
          end else begin
            num_r <= NW'($signed(SQW'(sum_raw)) - $signed(SQW'(nb_r))) <<< 4;
          end
          state <= S_CMP;
        end

        S_CMP: begin
          acc_r   <= (EW'(num_r) > EW'(thrn_r)) && (int'(wave_det) < NUM_DETECTORS);
          neg_num <= num_r[NW-1];
          dvd     <= num_r[NW-1] ? NW'(-num_r) : NW'(num_r);
          rem     <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end

        // Restoring divide, one quotient bit per cycle
        S_DIV: begin
          if (rem_sh >= {1'b0, n_r}) begin
            rem <= rem_sh - {1'b0, n_r};
            dvd <= {dvd[NW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            dvd <= {dvd[NW-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (int'(div_cnt) == NW - 1) begin
            state <= S_FIN;
          end
        end

        // Summary with floor rounding and saturation
        S_FIN: begin
          kind            <= KIND_SUMMARY;
          accepted        <= acc_r;
          bin_sum         <= '0;
          bin_sum_squares <= '0;
          if (mean_mag > (NW+1)'(MEAN_LIM)) begin
            event_mean <= neg_num ? -MEAN_W'(MEAN_LIM) : MEAN_W'(MEAN_LIM);
          end else begin
            event_mean <= neg_num ? -MEAN_W'(mean_mag) : MEAN_W'(mean_mag);
          end
          ai    <= '0;
          state <= acc_r ? S_ARD : S_IDLE;
        end

        S_ARD: begin
          acc_addr <= acc_raddr;
          state    <= S_ACALC;
        end

        S_ACALC: begin
          q_r     <= q_now;
          sq_r    <= PW'(q_now) * PW'(q_now);
          cur_sum <= sum_rdata;
          cur_sq  <= sq_rdata;
          state   <= S_AWR;
        end

        S_AWR: begin
          ai <= ai + 1'b1;
          state <= (ai + 1'b1 == n_r) ? S_IDLE : S_ARD;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/mbgwa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mbgwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mbgwa_checker.sv
// Port-level checker for the averager and its bind to the top level.
module mbgwa_checker
  import mbgwa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              operation,
  input logic              done,
  input logic              kind,
  input logic [SUM_W-1:0]  bin_sum,
  input logic [SQ_W-1:0]   bin_sum_squares
);

  // Reset starts the clearing pass
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // A read transfer is followed by a readout result
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_READ) |=> ##1 (done && kind == KIND_READOUT))
    else $error("read result missing");

  // A read transfer holds off the next command
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_READ) |=> busy)
    else $error("not busy after read");

  // Results never come in adjacent cycles
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back to back results");

  // Summaries carry zero sums
  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    (done && kind == KIND_SUMMARY) |-> (bin_sum == '0 && bin_sum_squares == '0))
    else $error("summary with nonzero sums");

endmodule

bind median_baseline_gated_wave_averager mbgwa_checker u_mbgwa_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
  .done(done), .kind(kind), .bin_sum(bin_sum), .bin_sum_squares(bin_sum_squares)
);

FILE: dv/tb_median_baseline_gated_wave_averager.sv
// Testbench for the median-baseline gated waveform averager: directed table plus random waves.
`timescale 1ns / 100ps

module tb_median_baseline_gated_wave_averager;
  import mbgwa_pkg::*;

  localparam longint SUM_HI = 64'sd549755813887;
  localparam longint SUM_LO = -64'sd549755813888;
  localparam longint unsigned SQ_HI = 64'hFFFF_FFFF_FFFF;
  localparam int WAVE_MAX = 1024;
  // covers the accumulation pass after a summary, which gives no result
  localparam int DRAIN_CYCLES = 3 * WAVE_MAX + 200;

  typedef struct packed {
    kind_t                    kind;
    logic [DET_W-1:0]         det;
    logic signed [MEAN_W-1:0] mean;
    logic                     acc;
    logic signed [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]          sq;
  } result_t;

  typedef struct {
    bit               is_cfg;
    cfg_idx_t         idx;
    logic [19:0]      data;
    op_t              op;
    logic [DET_W-1:0] det;
    logic [13:0]      smp;
    logic [BIN_W-1:0] bin;
    bit               fixed;
    result_t          want;
  } step_t;

  logic clk, rst, start, busy, operation, done, kind, accepted, cfg_valid, cfg_ready;
  logic [DET_W-1:0] detector, source_detector;
  logic [13:0] sample;
  logic [BIN_W-1:0] bin_index;
  logic signed [MEAN_W-1:0] event_mean;
  logic signed [SUM_W-1:0] bin_sum;
  logic [SQ_W-1:0] bin_sum_squares;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  median_baseline_gated_wave_averager DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .detector(detector), .sample(sample), .bin_index(bin_index), .done(done),
    .kind(kind), .source_detector(source_detector), .event_mean(event_mean),
    .accepted(accepted), .bin_sum(bin_sum), .bin_sum_squares(bin_sum_squares),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state: configuration, current waveform, per-bin accumulators
  logic [3:0]       neg_mask;
  logic [10:0]      len_reg;
  longint           thr;
  logic [13:0]      wave_samples [WAVE_MAX];
  int               fill_count;
  logic [DET_W-1:0] wave_owner;
  longint           acc_sum [4*WAVE_MAX];
  longint unsigned  acc_sq [4*WAVE_MAX];

  result_t pending_results [$];
  step_t   plan [$];
  int      mism_count;
  bit      no_idle;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Expected result of one item; returns 1 when the item yields a result
  function automatic bit predict_item(op_t op, logic [DET_W-1:0] det, logic [13:0] smp,
                                      logic [BIN_W-1:0] bin, output result_t r);
    int n, k, lo, le, base, eff, idx;
    longint total, num, mean, q, s;
    longint unsigned sqv;
    bit flip, take;
    r = '0;
    if (op == OP_READ) begin
      idx = int'(det) * WAVE_MAX + int'(bin);
      r.kind = KIND_READOUT;
      r.det  = det;
      r.sum  = acc_sum[idx][SUM_W-1:0];
      r.sq   = acc_sq[idx][SQ_W-1:0];
      return 1'b1;
    end
    if (fill_count == 0) wave_owner = det;
    if (fill_count < WAVE_MAX) begin
      wave_samples[fill_count] = smp;
      fill_count++;
    end
    eff = (len_reg == 0) ? 1 : (len_reg > WAVE_MAX) ? WAVE_MAX : int'(len_reg);
    if (fill_count < eff) return 1'b0;
    n = fill_count;
    fill_count = 0;
    // baseline: the value whose rank range covers n/2
    k = n / 2;
    base = 0;
    for (int i = 0; i < n; i++) begin
      lo = 0;
      le = 0;
      for (int j = 0; j < n; j++) begin
        if (wave_samples[j] < wave_samples[i]) lo++;
        if (wave_samples[j] <= wave_samples[i]) le++;
      end
      if (lo <= k && k < le) begin
        base = int'(wave_samples[i]);
        break;
      end
    end
    flip = neg_mask[wave_owner];
    total = 0;
    for (int i = 0; i < n; i++) begin
      q = longint'(wave_samples[i]) - base;
      total += flip ? -q : q;
    end
    num = total * 16;
    mean = (num >= 0) ? num / n : -((-num + n - 1) / n);
    if (mean > MEAN_LIM) mean = MEAN_LIM;
    if (mean < -MEAN_LIM) mean = -MEAN_LIM;
    take = num > thr * n;
    if (take) begin
      for (int i = 0; i < n; i++) begin
        idx = int'(wave_owner) * WAVE_MAX + i;
        q = longint'(wave_samples[i]) - base;
        if (flip) q = -q;
        s = acc_sum[idx] + q;
        acc_sum[idx] = (s > SUM_HI) ? SUM_HI : (s < SUM_LO) ? SUM_LO : s;
        sqv = longint'(q * q);
        acc_sq[idx] = (acc_sq[idx] > SQ_HI - sqv) ? SQ_HI : acc_sq[idx] + sqv;
      end
    end
    r.kind = KIND_SUMMARY;
    r.det  = wave_owner;
    r.mean = mean[MEAN_W-1:0];
    r.acc  = take;
    return 1'b1;
  endfunction

  // One command transfer; random gap before it unless idling is off
  task automatic send(op_t op, logic [DET_W-1:0] det, logic [13:0] smp, logic [BIN_W-1:0] bin,
                      bit fixed = 1'b0, result_t want = '0);
    result_t r;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    detector  <= det;
    sample    <= smp;
    bin_index <= bin;
    do @(posedge clk); while (busy);
    if (predict_item(op, det, smp, bin, r)) pending_results.push_back(fixed ? want : r);
  endtask

  // Wait until all results are in and the block has had time to finish its pass
  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; the predictor takes the same value
  task automatic write_reg(cfg_idx_t idx, logic [19:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_NEGATE: neg_mask = data[3:0];
      CFG_LENGTH: len_reg = data[10:0];
      CFG_THRESH: thr = longint'(signed'(data));
      default: ;
    endcase
  endtask

  task automatic add_cfg(cfg_idx_t idx, logic [19:0] data);
    step_t s;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    s.op = OP_PUSH;
    s.det = '0;
    s.smp = '0;
    s.bin = '0;
    s.fixed = 1'b0;
    s.want = '0;
    plan.push_back(s);
  endtask

  task automatic add_item(op_t op, logic [DET_W-1:0] det, logic [13:0] smp,
                          logic [BIN_W-1:0] bin, bit fixed = 1'b0, result_t want = '0);
    step_t s;
    s.is_cfg = 1'b0;
    s.idx = CFG_NEGATE;
    s.data = '0;
    s.op = op;
    s.det = det;
    s.smp = smp;
    s.bin = bin;
    s.fixed = fixed;
    s.want = want;
    plan.push_back(s);
  endtask

  // Result checker: one transfer per done cycle
  always @(posedge clk) begin : check_results
    result_t w;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d detector %0d", kind, source_detector);
        mism_count++;
      end else begin
        w = pending_results.pop_front();
        if (kind !== w.kind) begin
          $error("kind: expected %0d actual %0d", w.kind, kind); mism_count++;
        end
        if (source_detector !== w.det) begin
          $error("source_detector: expected %0d actual %0d", w.det, source_detector);
          mism_count++;
        end
        if (event_mean !== w.mean) begin
          $error("event_mean: expected %0d actual %0d", w.mean, event_mean); mism_count++;
        end
        if (accepted !== w.acc) begin
          $error("accepted: expected %0d actual %0d", w.acc, accepted); mism_count++;
        end
        if (bin_sum !== w.sum) begin
          $error("bin_sum: expected %0d actual %0d", w.sum, bin_sum); mism_count++;
        end
        if (bin_sum_squares !== w.sq) begin
          $error("bin_sum_squares: expected %0d actual %0d", w.sq, bin_sum_squares);
          mism_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    result_t zero_rd, zero_sum;
    step_t st;
    logic [DET_W-1:0] cur_det;
    int center, v;
    logic [19:0] thr_val;
    logic [10:0] len_val;

    rst = 1'b1;
    start = 1'b0;
    operation = OP_PUSH;
    detector = '0;
    sample = '0;
    bin_index = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NEGATE;
    cfg_data = '0;
    mism_count = 0;
    no_idle = 1'b0;
    neg_mask = '0;
    len_reg = LEN_RESET;
    thr = 8;
    fill_count = 0;
    wave_owner = '0;
    for (int i = 0; i < 4 * WAVE_MAX; i++) begin
      acc_sum[i] = 0;
      acc_sq[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    zero_rd = '{KIND_READOUT, 2'd0, 20'sd0, 1'b0, 40'sd0, 48'd0};
    zero_sum = '{KIND_SUMMARY, 2'd0, 20'sd0, 1'b0, 40'sd0, 48'd0};

    // Directed: reset contents, length extremes, polarity, threshold extremes,
    // detector switch and length change inside a waveform
    add_item(OP_READ, 2'd0, 14'd0, 10'd0, 1'b1, zero_rd);
    zero_rd.det = 2'd3;
    add_item(OP_READ, 2'd3, 14'h3FFF, 10'd1023, 1'b1, zero_rd);
    add_cfg(CFG_LENGTH, 20'd0);
    zero_sum.det = 2'd2;
    add_item(OP_PUSH, 2'd2, 14'd0, 10'd0, 1'b1, zero_sum);
    zero_sum.det = 2'd1;
    add_item(OP_PUSH, 2'd1, 14'h3FFF, 10'd0, 1'b1, zero_sum);
    add_cfg(CFG_THRESH, 20'hFFFFF);
    zero_sum.det = 2'd3;
    zero_sum.acc = 1'b1;
    add_item(OP_PUSH, 2'd3, 14'd12345, 10'd0, 1'b1, zero_sum);
    add_item(OP_READ, 2'd3, 14'd0, 10'd0, 1'b1, zero_rd);
    add_cfg(CFG_LENGTH, 20'd2);
    add_item(OP_PUSH, 2'd0, 14'd0, 10'd0);
    add_item(OP_PUSH, 2'd2, 14'h3FFF, 10'd0);
    add_cfg(CFG_NEGATE, 20'hF);
    add_cfg(CFG_THRESH, 20'hC0000);
    add_item(OP_PUSH, 2'd1, 14'd0, 10'd0);
    add_item(OP_PUSH, 2'd1, 14'h3FFF, 10'd0);
    add_item(OP_READ, 2'd1, 14'd0, 10'd0);
    add_item(OP_READ, 2'd1, 14'd0, 10'd1);
    add_cfg(CFG_LENGTH, 20'd2047);
    add_item(OP_PUSH, 2'd0, 14'd5, 10'd0);
    add_item(OP_PUSH, 2'd3, 14'd7, 10'd0);
    add_item(OP_READ, 2'd0, 14'd0, 10'd0);
    add_item(OP_PUSH, 2'd0, 14'd9, 10'd0);
    add_cfg(CFG_LENGTH, 20'd3);
    add_item(OP_PUSH, 2'd1, 14'd1, 10'd0);
    add_item(OP_READ, 2'd0, 14'd0, 10'd3);
    add_cfg(CFG_THRESH, 20'h40000);
    add_cfg(CFG_NEGATE, 20'h0);

    foreach (plan[i]) begin
      st = plan[i];
      if (st.is_cfg) begin
        settle();
        write_reg(st.idx, st.data);
      end else begin
        send(st.op, st.det, st.smp, st.bin, st.fixed, st.want);
      end
    end

    // Long waveform sent back to back
    settle();
    write_reg(CFG_LENGTH, 20'd300);
    write_reg(CFG_THRESH, 20'hC0000);
    write_reg(CFG_NEGATE, 20'd4);
    cur_det = 2'($urandom_range(0, 3));
    no_idle = 1'b1;
    repeat (300) send(OP_PUSH, cur_det, 14'($urandom), 10'd0);
    no_idle = 1'b0;
    settle();
    repeat (4) send(OP_READ, cur_det, 14'($urandom), 10'($urandom_range(0, 299)));

    // Random phases: every register rewritten; short waves with random content
    for (int ph = 0; ph < 7; ph++) begin
      settle();
      case (ph % 4)
        0: thr_val = 20'hC0000;
        1: thr_val = 20'h40000;
        2: thr_val = 20'($urandom_range(0, 600) - 300);
        default: thr_val = 20'($urandom);
      endcase
      len_val = (ph == 0) ? 11'd1 : (ph == 1) ? 11'd0 : (ph == 2) ? 11'd2 :
                11'($urandom_range(1, 40));
      write_reg(CFG_NEGATE, 20'($urandom_range(0, 15)));
      write_reg(CFG_LENGTH, {9'd0, len_val});
      write_reg(CFG_THRESH, thr_val);
      no_idle = (ph >= 5);
      center = $urandom_range(0, 16383);
      cur_det = 2'($urandom_range(0, 3));
      repeat (45) begin
        if ($urandom_range(0, 4) == 0) begin
          send(OP_READ, 2'($urandom_range(0, 3)), 14'($urandom),
               ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 47)) : 10'($urandom));
        end else begin
          // new waveform: fresh detector and signal level
          if (fill_count == 0) begin
            cur_det = 2'($urandom_range(0, 3));
            center = $urandom_range(0, 16383);
          end
          if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 16383);
          else v = center + $urandom_range(0, 200) - 64;
          if (v < 0) v = 0;
          if (v > 16383) v = 16383;
          send(OP_PUSH, ($urandom_range(0, 15) == 0) ? 2'($urandom) : cur_det, 14'(v),
               10'($urandom));
        end
      end
    end

    // Drain
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mism_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
